@@ design/mvfl_pkg.sv @@
// Shared types, constants and elaboration-time functions for the mesh vertex frame lerp.
// Used by every module of the block; it depends on nothing else.
package mvfl_pkg;

   // Field widths fixed by the beat formats.
   localparam int POS_W       = 16;
   localparam int BLEND_W     = 24;
   localparam int NORMAL_W    = 16;
   localparam int WEIGHT_W    = 9;
   localparam int SCALE_W     = 8;
   localparam int POS_PROD_W  = 25;
   localparam int ANGLE_BYTE_W = 8;

   // Full weight of one frame in Q1.8.
   localparam logic [WEIGHT_W-1:0] WEIGHT_ONE = 9'd256;

   // Register port geometry and register indexes.
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;
   localparam logic REG_BACKLERP_WEIGHT = 1'b0;

   // Pi/2 in unsigned Q2.62.
   localparam logic [63:0] PI_HALF_Q62 = 64'h6487_ED51_10B4_611A;

   // Taylor series divisors (2n)(2n+1) for n = 1..13.
   localparam longint unsigned TAYLOR_DIV [13] = '{
      64'd6, 64'd20, 64'd42, 64'd72, 64'd110, 64'd156, 64'd210,
      64'd272, 64'd342, 64'd420, 64'd506, 64'd600, 64'd702
   };

   typedef struct packed {
      logic signed [POS_W-1:0] old_x;
      logic signed [POS_W-1:0] old_y;
      logic signed [POS_W-1:0] old_z;
      logic [POS_W-1:0]        old_packed_normal;
      logic signed [POS_W-1:0] new_x;
      logic signed [POS_W-1:0] new_y;
      logic signed [POS_W-1:0] new_z;
      logic [POS_W-1:0]        new_packed_normal;
   } req_beat_type;

   typedef struct packed {
      logic signed [BLEND_W-1:0]  blend_x;
      logic signed [BLEND_W-1:0]  blend_y;
      logic signed [BLEND_W-1:0]  blend_z;
      logic signed [NORMAL_W-1:0] normal_x;
      logic signed [NORMAL_W-1:0] normal_y;
      logic signed [NORMAL_W-1:0] normal_z;
   } rsp_beat_type;

   // Weights derived from the backlerp register.
   typedef struct packed {
      logic [WEIGHT_W-1:0] old_weight;
      logic [WEIGHT_W-1:0] new_weight;
      logic [SCALE_W-1:0]  angle_scale;
      logic                copy_new;
   } weight_cfg_type;

   // Unsigned Q2.62 product, keeping the low 64 bits of the scaled result.
   function automatic logic [63:0] mul_q62(input logic [63:0] a, input logic [63:0] b);
      logic [127:0] prod;
      prod = {64'd0, a} * {64'd0, b};
      return prod[125:62];
   endfunction

   // Sine of k steps out of a quarter turn of 2^log2_quarter steps, rounded to frac bits.
   function automatic int quarter_sine(input int k, input int log2_quarter, input int frac);
      logic [63:0] x;
      logic [63:0] x2;
      logic [63:0] term;
      logic [63:0] sum;
      int          sh;
      x    = (PI_HALF_Q62 >> log2_quarter) * 64'(k);
      x2   = mul_q62(x, x);
      term = x;
      sum  = x;
      sh   = 62 - frac;
      for (int n = 1; n <= 13; n++) begin
         term = mul_q62(term, x2) / TAYLOR_DIV[n-1];
         if ((n % 2) == 1) begin
            sum = sum - term;
         end else begin
            sum = sum + term;
         end
      end
      return int'((sum + (64'd1 << (sh - 1))) >> sh);
   endfunction

   // One entry of the full-circle sine table, folded onto the first quadrant.
   function automatic int sine_entry(input int idx, input int log2_size, input int frac);
      int quarter;
      int half;
      int size;
      int value;
      quarter = 1 << (log2_size - 2);
      half    = 2 * quarter;
      size    = 4 * quarter;
      if (idx <= quarter) begin
         value = quarter_sine(idx, log2_size - 2, frac);
      end else if (idx <= half) begin
         value = quarter_sine(half - idx, log2_size - 2, frac);
      end else if (idx <= 3 * quarter) begin
         value = -quarter_sine(idx - half, log2_size - 2, frac);
      end else begin
         value = -quarter_sine(size - idx, log2_size - 2, frac);
      end
      return value;
   endfunction

endpackage

@@ design/mvfl_csr.sv @@
// Backlerp weight register behind the APB-style port, plus the weights derived from it.
// Depends on mvfl_pkg for widths, register indexes and the weight struct.
module mvfl_csr (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_psel,
   input  logic                                 csr_penable,
   input  logic                                 csr_pwrite,
   input  logic [mvfl_pkg::CSR_ADDR_W-1:0]      csr_paddr,
   input  logic [mvfl_pkg::CSR_DATA_W-1:0]      csr_pwdata,
   output logic [mvfl_pkg::CSR_DATA_W-1:0]      csr_prdata,
   output logic                                 csr_pready,
   output mvfl_pkg::weight_cfg_type             weight_cfg
);
   import mvfl_pkg::*;

   logic [WEIGHT_W-1:0]      weight_ff;
   logic [WEIGHT_W-1:0]      weight_in;
   logic                     reg_index;
   logic                     write_beat;
   logic [WEIGHT_W-1:0]      old_weight;
   logic [WEIGHT_W-1:0]      new_weight;
   logic [WEIGHT_W+7:0]      scale_wide;

   assign reg_index  = csr_paddr[2];
   assign write_beat = csr_psel && csr_penable && csr_pwrite;
   assign csr_pready = 1'b1;

   // Register write decode; writes to other indexes are dropped.
   always_comb begin
      weight_in = weight_ff;
      if (write_beat) begin
         unique case (reg_index)
            REG_BACKLERP_WEIGHT: weight_in = csr_pwdata[WEIGHT_W-1:0];
            default:             weight_in = weight_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         weight_ff <= '0;
      end else begin
         weight_ff <= weight_in;
      end
   end

   // Read decode.
   always_comb begin
      unique case (reg_index)
         REG_BACKLERP_WEIGHT: csr_prdata = CSR_DATA_W'(weight_ff);
         default:             csr_prdata = '0;
      endcase
   end

   // Clamp the weight to one and derive the new-frame and angle weights.
   always_comb begin
      old_weight = (weight_ff > WEIGHT_ONE) ? WEIGHT_ONE : weight_ff;
      new_weight = WEIGHT_ONE - old_weight;
      scale_wide = ({new_weight, 8'd0} - (WEIGHT_W+8)'(new_weight)) >> 8;
      weight_cfg.old_weight  = old_weight;
      weight_cfg.new_weight  = new_weight;
      weight_cfg.angle_scale = scale_wide[SCALE_W-1:0];
      weight_cfg.copy_new    = (old_weight == '0);
   end

endmodule

@@ design/mvfl_sine_rom.sv @@
// Full-circle sine table with two registered read ports, built at elaboration.
// Depends on mvfl_pkg for the table entry function.
module mvfl_sine_rom #(
   parameter int SIZE = 1024,
   parameter int FRAC = 14
) (
   input  logic                       clock,
   input  logic                       enable,
   input  logic [$clog2(SIZE)-1:0]    addr_a,
   input  logic [$clog2(SIZE)-1:0]    addr_b,
   output logic signed [FRAC+1:0]     data_a,
   output logic signed [FRAC+1:0]     data_b
);
   import mvfl_pkg::*;

   localparam int AW = $clog2(SIZE);
   localparam int RW = FRAC + 2;

   logic signed [RW-1:0] rom_table [SIZE];
   logic signed [RW-1:0] data_a_ff;
   logic signed [RW-1:0] data_b_ff;

   // Constant table contents, one entry per angle step.
   for (genvar i = 0; i < SIZE; i++) begin : gen_entry
      localparam int ENTRY = sine_entry(i, AW, FRAC);
      assign rom_table[i] = RW'(ENTRY);
   end

   // Registered reads advance with the pipeline stage that owns them.
   always_ff @(posedge clock) begin
      if (enable) begin
         data_a_ff <= rom_table[addr_a];
         data_b_ff <= rom_table[addr_b];
      end
   end

   assign data_a = data_a_ff;
   assign data_b = data_b_ff;

endmodule

@@ design/mesh_vertex_frame_lerp.sv @@
// Mesh vertex frame lerp: blends one vertex between two animation frames per beat.
// Each request beat carries the old and new frame's position and packed normal; each
// response beat carries the blended position (raw units times 256) and the decoded
// unit normal in signed Q1.14. The backlerp weight is set through the csr_ port
// (register 0, byte address 0) and must only be written while no beat is in flight.
// A weight of zero passes the new frame straight through.
// The datapath is a five-stage pipeline: weight products and angle deltas, blend sums
// and angle interpolation, sine table reads, normal products, rounding into the
// output register. An accepted beat moves through the stage registers in order to rsp_,
// and one beat per cycle is accepted for as long as the output is not stalled.
// Each stage moves forward whenever the stage after it is empty or moving, so
// rsp_stall holds the output beat and fills bubbles upstream; req_stall rises only
// once every stage holds a beat. Reset empties the pipeline and clears the weight to
// zero; the sine tables are constants and need no fill time.
module mesh_vertex_frame_lerp #(
   parameter int ANGLE_TABLE_SIZE   = 1024,
   parameter int SINE_FRACTION_BITS = 14
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  mvfl_pkg::req_beat_type             req_data,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output mvfl_pkg::rsp_beat_type             rsp_data,
   input  logic                               csr_psel,
   input  logic                               csr_penable,
   input  logic                               csr_pwrite,
   input  logic [mvfl_pkg::CSR_ADDR_W-1:0]    csr_paddr,
   input  logic [mvfl_pkg::CSR_DATA_W-1:0]    csr_pwdata,
   output logic [mvfl_pkg::CSR_DATA_W-1:0]    csr_prdata,
   output logic                               csr_pready
);
   import mvfl_pkg::*;

   localparam int AW  = $clog2(ANGLE_TABLE_SIZE);
   localparam int RW  = SINE_FRACTION_BITS + 2;
   localparam int PRW = 2 * RW;
   localparam int APW = AW + 1 + SCALE_W + 1;
   localparam logic [AW-1:0]        QUARTER   = AW'(ANGLE_TABLE_SIZE / 4);
   localparam logic signed [AW:0]   HALF_TURN = (AW+1)'(ANGLE_TABLE_SIZE / 2);
   localparam logic signed [AW:0]   FULL_TURN = (AW+1)'(ANGLE_TABLE_SIZE);
   localparam logic signed [PRW-1:0] ROUND_HALF = PRW'(1) <<< (SINE_FRACTION_BITS - 1);

   weight_cfg_type weight_cfg;

   mvfl_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .weight_cfg  (weight_cfg)
   );

   // Stage valids and enables.
   logic v1_ff, v2_ff, v3_ff, v4_ff, v5_ff;
   logic en1, en2, en3, en4, en5;

   assign en5 = !v5_ff || !rsp_stall;
   assign en4 = !v4_ff || en5;
   assign en3 = !v3_ff || en4;
   assign en2 = !v2_ff || en3;
   assign en1 = !v1_ff || en2;
   assign req_stall = !en1;
   assign rsp_valid = v5_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
         v5_ff <= 1'b0;
      end else begin
         if (en1) v1_ff <= req_valid;
         if (en2) v2_ff <= v1_ff;
         if (en3) v3_ff <= v2_ff;
         if (en4) v4_ff <= v3_ff;
         if (en5) v5_ff <= v4_ff;
      end
   end

   // Stage 1: weighted position products and wrapped angle deltas.
   logic signed [POS_PROD_W-1:0] old_px_ff, old_py_ff, old_pz_ff;
   logic signed [POS_PROD_W-1:0] new_px_ff, new_py_ff, new_pz_ff;
   logic signed [POS_PROD_W-1:0] old_px_in, old_py_in, old_pz_in;
   logic signed [POS_PROD_W-1:0] new_px_in, new_py_in, new_pz_in;
   logic [AW-1:0]                lat_base_ff, lon_base_ff, lat_base_in, lon_base_in;
   logic signed [AW:0]           lat_diff_ff, lon_diff_ff, lat_diff_in, lon_diff_in;
   logic signed [POS_PROD_W-1:0] old_w_s, new_w_s;
   logic [AW-1:0]                lat_old_ang, lon_old_ang;

   // Wrap an angle delta into half a turn.
   function automatic logic signed [AW:0] wrap_delta(input logic [AW-1:0] old_ang,
                                                       input logic [AW-1:0] new_ang);
      logic signed [AW:0] d;
      d = $signed({1'b0, old_ang}) - $signed({1'b0, new_ang});
      if (d < -HALF_TURN) begin
         d = d + FULL_TURN;
      end else if (d > HALF_TURN) begin
         d = d - FULL_TURN;
      end
      return d;
   endfunction

   always_comb begin
      old_w_s   = $signed(POS_PROD_W'(weight_cfg.old_weight));
      new_w_s   = $signed(POS_PROD_W'(weight_cfg.new_weight));
      old_px_in = POS_PROD_W'(req_data.old_x) * old_w_s;
      old_py_in = POS_PROD_W'(req_data.old_y) * old_w_s;
      old_pz_in = POS_PROD_W'(req_data.old_z) * old_w_s;
      new_px_in = POS_PROD_W'(req_data.new_x) * new_w_s;
      new_py_in = POS_PROD_W'(req_data.new_y) * new_w_s;
      new_pz_in = POS_PROD_W'(req_data.new_z) * new_w_s;
      lat_base_in = AW'(req_data.new_packed_normal[15:8]) << (AW - ANGLE_BYTE_W);
      lon_base_in = AW'(req_data.new_packed_normal[7:0]) << (AW - ANGLE_BYTE_W);
      lat_old_ang = AW'(req_data.old_packed_normal[15:8]) << (AW - ANGLE_BYTE_W);
      lon_old_ang = AW'(req_data.old_packed_normal[7:0]) << (AW - ANGLE_BYTE_W);
      // With no old-frame weight the new angles pass through unchanged.
      if (weight_cfg.copy_new) begin
         lat_diff_in = '0;
         lon_diff_in = '0;
      end else begin
         lat_diff_in = wrap_delta(lat_old_ang, lat_base_in);
         lon_diff_in = wrap_delta(lon_old_ang, lon_base_in);
      end
   end

   always_ff @(posedge clock) begin
      if (en1) begin
         old_px_ff   <= old_px_in;
         old_py_ff   <= old_py_in;
         old_pz_ff   <= old_pz_in;
         new_px_ff   <= new_px_in;
         new_py_ff   <= new_py_in;
         new_pz_ff   <= new_pz_in;
         lat_base_ff <= lat_base_in;
         lon_base_ff <= lon_base_in;
         lat_diff_ff <= lat_diff_in;
         lon_diff_ff <= lon_diff_in;
      end
   end

   // Stage 2: position sums and interpolated angles.
   logic signed [BLEND_W-1:0] bx2_ff, by2_ff, bz2_ff, bx2_in, by2_in, bz2_in;
   logic [AW-1:0]             lat_ang_ff, lon_ang_ff, lat_ang_in, lon_ang_in;
   logic signed [APW-1:0]     lat_prod, lon_prod;
   logic signed [APW-1:0]     scale_s;

   always_comb begin
      bx2_in     = BLEND_W'(old_px_ff + new_px_ff);
      by2_in     = BLEND_W'(old_py_ff + new_py_ff);
      bz2_in     = BLEND_W'(old_pz_ff + new_pz_ff);
      scale_s    = $signed(APW'(weight_cfg.angle_scale));
      lat_prod   = APW'(lat_diff_ff) * scale_s;
      lon_prod   = APW'(lon_diff_ff) * scale_s;
      lat_ang_in = lat_base_ff + AW'(lat_prod >>> 8);
      lon_ang_in = lon_base_ff + AW'(lon_prod >>> 8);
   end

   always_ff @(posedge clock) begin
      if (en2) begin
         bx2_ff     <= bx2_in;
         by2_ff     <= by2_in;
         bz2_ff     <= bz2_in;
         lat_ang_ff <= lat_ang_in;
         lon_ang_ff <= lon_ang_in;
      end
   end

   // Stage 3: sine and cosine lookups for both angles.
   logic signed [BLEND_W-1:0] bx3_ff, by3_ff, bz3_ff;
   logic signed [RW-1:0]      cos_lat, sin_lat, sin_lon, cos_lon;

   mvfl_sine_rom #(
      .SIZE (ANGLE_TABLE_SIZE),
      .FRAC (SINE_FRACTION_BITS)
   ) u_lat_rom (
      .clock  (clock),
      .enable (en3),
      .addr_a (lat_ang_ff + QUARTER),
      .addr_b (lat_ang_ff),
      .data_a (cos_lat),
      .data_b (sin_lat)
   );

   mvfl_sine_rom #(
      .SIZE (ANGLE_TABLE_SIZE),
      .FRAC (SINE_FRACTION_BITS)
   ) u_lon_rom (
      .clock  (clock),
      .enable (en3),
      .addr_a (lon_ang_ff),
      .addr_b (lon_ang_ff + QUARTER),
      .data_a (sin_lon),
      .data_b (cos_lon)
   );

   always_ff @(posedge clock) begin
      if (en3) begin
         bx3_ff <= bx2_ff;
         by3_ff <= by2_ff;
         bz3_ff <= bz2_ff;
      end
   end

   // Stage 4: normal products in Q2.28.
   logic signed [BLEND_W-1:0] bx4_ff, by4_ff, bz4_ff;
   logic signed [PRW-1:0]     nx_prod_ff, ny_prod_ff, nx_prod_in, ny_prod_in;
   logic signed [RW-1:0]      nz4_ff;

   always_comb begin
      nx_prod_in = PRW'(cos_lat) * PRW'(sin_lon);
      ny_prod_in = PRW'(sin_lat) * PRW'(sin_lon);
   end

   always_ff @(posedge clock) begin
      if (en4) begin
         bx4_ff     <= bx3_ff;
         by4_ff     <= by3_ff;
         bz4_ff     <= bz3_ff;
         nx_prod_ff <= nx_prod_in;
         ny_prod_ff <= ny_prod_in;
         nz4_ff     <= cos_lon;
      end
   end

   // Stage 5: round half up into Q1.14 and load the output register.
   rsp_beat_type          rsp_data_ff, rsp_data_in;
   logic signed [PRW-1:0] nx_round, ny_round;

   always_comb begin
      nx_round = (nx_prod_ff + ROUND_HALF) >>> SINE_FRACTION_BITS;
      ny_round = (ny_prod_ff + ROUND_HALF) >>> SINE_FRACTION_BITS;
      rsp_data_in.blend_x  = bx4_ff;
      rsp_data_in.blend_y  = by4_ff;
      rsp_data_in.blend_z  = bz4_ff;
      rsp_data_in.normal_x = NORMAL_W'(nx_round);
      rsp_data_in.normal_y = NORMAL_W'(ny_round);
      rsp_data_in.normal_z = NORMAL_W'(nz4_ff);
   end

   always_ff @(posedge clock) begin
      if (en5) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_data = rsp_data_ff;

   // An accepted request beat always lands in the first stage.
   assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> v1_ff)
      else $error("accepted request beat did not enter stage one");

   // Back pressure only reaches the input once the first stage holds a beat.
   assert property (@(posedge clock) disable iff (reset)
      !v1_ff |-> !req_stall)
      else $error("request stalled with an empty first stage");

   // A stalled output beat keeps every upstream stage frozen when the pipe is full.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall && v4_ff && v3_ff && v2_ff && v1_ff) |-> req_stall)
      else $error("full pipeline accepted a beat under output stall");

   // With zero old-frame weight the angles are copied, so no delta enters stage two.
   assert property (@(posedge clock) disable iff (reset)
      (v1_ff && weight_cfg.copy_new) |-> (lat_diff_ff == '0 && lon_diff_ff == '0))
      else $error("angle delta present while copying the new frame");

endmodule

@@ bench/mesh_vertex_frame_lerp_tb.sv @@
`timescale 1ns / 100ps
// Self-checking bench for mesh_vertex_frame_lerp: streams vertex pairs under many backlerp
// weights and compares every response beat with a blend and normal decode predicted here.
// Depends on mvfl_pkg for the beat types and constants, and on the block's top level.
module mesh_vertex_frame_lerp_tb;
   import mvfl_pkg::*;

   localparam int TABLE_SIZE      = 1024;
   localparam int FRAC_BITS       = 14;
   localparam int ANGLE_STEP      = TABLE_SIZE / 256;
   localparam int QUARTER_TURN    = TABLE_SIZE / 4;
   localparam int HALF_TURN       = TABLE_SIZE / 2;
   localparam int RAND_PHASES     = 10;
   localparam int BEATS_PER_PHASE = 183;
   localparam int PRESSURE_PHASE  = 2;
   localparam int QUIET_PHASE     = 3;
   localparam int IDLE_PERCENT    = 19;
   localparam int HOLD_OFF_CYCLES = 200;
   localparam int SETTLE_CYCLES   = 8;
   localparam int CYCLE_LIMIT     = 200000;
   localparam int UNUSED_REG_INDEX = 1;
   localparam int WEIGHT_REG_INDEX = int'(REG_BACKLERP_WEIGHT);

   // Predicts each response beat and holds the ones still outstanding.
   class vertex_blend_scoreboard;
      int                  sine_table[TABLE_SIZE];
      logic [WEIGHT_W-1:0] weight;
      rsp_beat_type        pending_blends[$];
      int                  accepted;
      int                  checked;
      int                  mismatches;

      function new();
         for (int i = 0; i < TABLE_SIZE; i++) begin
            if (i <= QUARTER_TURN) begin
               sine_table[i] = first_quadrant_sine(i);
            end else if (i <= HALF_TURN) begin
               sine_table[i] = first_quadrant_sine(HALF_TURN - i);
            end else if (i <= 3 * QUARTER_TURN) begin
               sine_table[i] = -first_quadrant_sine(i - HALF_TURN);
            end else begin
               sine_table[i] = -first_quadrant_sine(TABLE_SIZE - i);
            end
         end
         weight     = '0;
         accepted   = 0;
         checked    = 0;
         mismatches = 0;
      endfunction

      // Unsigned Q2.62 times Q2.62, keeping the low 64 bits of the Q2.62 result.
      function bit [63:0] q62_product(bit [63:0] a, bit [63:0] b);
         bit [127:0] full;
         full = 128'(a) * 128'(b);
         return 64'(full >> 62);
      endfunction

      // Taylor series for the sine of k steps of a quarter turn, rounded to FRAC_BITS.
      function int first_quadrant_sine(int k);
         bit [63:0] angle;
         bit [63:0] angle_sq;
         bit [63:0] term;
         bit [63:0] sum;
         angle    = (PI_HALF_Q62 / 64'(QUARTER_TURN)) * 64'(k);
         angle_sq = q62_product(angle, angle);
         term     = angle;
         sum      = angle;
         for (int n = 1; n <= 13; n++) begin
            term = q62_product(term, angle_sq) / 64'((2 * n) * (2 * n + 1));
            if (n % 2 == 1) begin
               sum = sum - term;
            end else begin
               sum = sum + term;
            end
         end
         return int'((sum + (64'd1 << (61 - FRAC_BITS))) >> (62 - FRAC_BITS));
      endfunction

      function int sine_at(int idx);
         return sine_table[idx & (TABLE_SIZE - 1)];
      endfunction

      // Rounds a Q2.28 product half up into Q1.14.
      function int round_q14(int a, int b);
         return (a * b + (1 << (FRAC_BITS - 1))) >>> FRAC_BITS;
      endfunction

      // Moves the new angle toward the old one along the shorter way round.
      function int interp_angle(logic [7:0] old_byte, logic [7:0] new_byte, int scale);
         int base;
         int diff;
         base = int'(new_byte) * ANGLE_STEP;
         diff = int'(old_byte) * ANGLE_STEP - base;
         if (diff < -HALF_TURN) begin
            diff = diff + TABLE_SIZE;
         end else if (diff > HALF_TURN) begin
            diff = diff - TABLE_SIZE;
         end
         return base + ((diff * scale) >>> 8);
      endfunction

      function rsp_beat_type blend_vertex(req_beat_type v);
         rsp_beat_type r;
         int old_w;
         int new_w;
         int scale;
         int lat_a;
         int lon_a;
         int lon_s;
         // Weights above one full unit behave as one full unit.
         old_w = (weight > WEIGHT_ONE) ? 256 : int'(weight);
         new_w = 256 - old_w;
         r.blend_x = BLEND_W'(int'($signed(v.old_x)) * old_w + int'($signed(v.new_x)) * new_w);
         r.blend_y = BLEND_W'(int'($signed(v.old_y)) * old_w + int'($signed(v.new_y)) * new_w);
         r.blend_z = BLEND_W'(int'($signed(v.old_z)) * old_w + int'($signed(v.new_z)) * new_w);

         // A zero weight takes the new frame's angles unchanged.
         if (old_w == 0) begin
            lat_a = int'(v.new_packed_normal[15:8]) * ANGLE_STEP;
            lon_a = int'(v.new_packed_normal[7:0]) * ANGLE_STEP;
         end else begin
            scale = (new_w * 255) >>> 8;
            lat_a = interp_angle(v.old_packed_normal[15:8], v.new_packed_normal[15:8], scale);
            lon_a = interp_angle(v.old_packed_normal[7:0], v.new_packed_normal[7:0], scale);
         end
         lon_s = sine_at(lon_a);
         r.normal_x = NORMAL_W'(round_q14(sine_at(lat_a + QUARTER_TURN), lon_s));
         r.normal_y = NORMAL_W'(round_q14(sine_at(lat_a), lon_s));
         r.normal_z = NORMAL_W'(sine_at(lon_a + QUARTER_TURN));
         return r;
      endfunction

      function void load_weight(logic [WEIGHT_W-1:0] w);
         weight = w;
      endfunction

      function void note_vertex(req_beat_type v);
         pending_blends.push_back(blend_vertex(v));
         accepted++;
      endfunction

      function void compare_field(string label, logic signed [31:0] want,
                                  logic signed [31:0] seen);
         if (seen !== want) begin
            mismatches++;
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, label, want, seen);
         end
      endfunction

      function void check_result(rsp_beat_type got);
         rsp_beat_type want;
         checked++;
         if (pending_blends.size() == 0) begin
            mismatches++;
            $display("%0t: response beat with none outstanding, expected nothing, actual %h",
                     $time, got);
         end else begin
            want = pending_blends.pop_front();
            compare_field("blend_x", want.blend_x, got.blend_x);
            compare_field("blend_y", want.blend_y, got.blend_y);
            compare_field("blend_z", want.blend_z, got.blend_z);
            compare_field("normal_x", want.normal_x, got.normal_x);
            compare_field("normal_y", want.normal_y, got.normal_y);
            compare_field("normal_z", want.normal_z, got.normal_z);
         end
      endfunction

      function int pending();
         return pending_blends.size();
      endfunction
   endclass

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_stall;
   req_beat_type          req_data = '0;
   logic                  rsp_valid;
   logic                  rsp_stall = 1'b0;
   rsp_beat_type          rsp_data;
   logic                  csr_psel = 1'b0;
   logic                  csr_penable = 1'b0;
   logic                  csr_pwrite = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_paddr = '0;
   logic [CSR_DATA_W-1:0] csr_pwdata = '0;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   vertex_blend_scoreboard blend_board;
   bit idle_enable    = 1'b1;
   bit stall_enable   = 1'b1;
   bit pressure_armed = 1'b0;
   bit pressure_done  = 1'b0;

   mesh_vertex_frame_lerp u_dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_data    (rsp_data),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   // 10 ns clock.
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // One register access: a setup cycle, then an access cycle that ends on pready,
   // then the port goes idle before the next access may start.
   task automatic csr_cycle(input logic write_en, input int index,
                            input logic [CSR_DATA_W-1:0] wdata,
                            output logic [CSR_DATA_W-1:0] rdata);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= write_en;
      csr_paddr   <= CSR_ADDR_W'(index * 4);
      csr_pwdata  <= wdata;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      rdata = csr_prdata;
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      @(posedge clock);
   endtask

   task automatic verify_weight();
      logic [CSR_DATA_W-1:0] rdata;
      csr_cycle(1'b0, WEIGHT_REG_INDEX, '0, rdata);
      if (rdata !== CSR_DATA_W'(blend_board.weight)) begin
         blend_board.mismatches++;
         $display("%0t: backlerp_weight readback mismatch, expected %0d, actual %0d",
                  $time, blend_board.weight, rdata);
      end
   endtask

   task automatic program_weight(input logic [CSR_DATA_W-1:0] word);
      logic [CSR_DATA_W-1:0] rdata;
      csr_cycle(1'b1, WEIGHT_REG_INDEX, word, rdata);
      blend_board.load_weight(word[WEIGHT_W-1:0]);
      verify_weight();
   endtask

   // Offers one beat, with random idle cycles ahead of it, and waits until it is taken.
   task automatic send_beat(input req_beat_type beat);
      while (idle_enable && $urandom_range(99) < IDLE_PERCENT) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= beat;
      do @(posedge clock); while (req_stall);
      blend_board.note_vertex(beat);
   endtask

   // Stops offering, lets every outstanding beat come back and the pipeline go quiet.
   task automatic close_phase();
      req_valid <= 1'b0;
      while (blend_board.pending() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   function automatic req_beat_type make_vertex(int ox, int oy, int oz, int on,
                                                 int nx, int ny, int nz, int nn);
      req_beat_type v;
      v.old_x = 16'(ox);
      v.old_y = 16'(oy);
      v.old_z = 16'(oz);
      v.old_packed_normal = 16'(on);
      v.new_x = 16'(nx);
      v.new_y = 16'(ny);
      v.new_z = 16'(nz);
      v.new_packed_normal = 16'(nn);
      return v;
   endfunction

   // Positions lean toward the extremes now and then.
   function automatic logic [15:0] random_position();
      case ($urandom_range(15))
         0: return 16'h8000;
         1: return 16'h7FFF;
         2: return 16'h0000;
         3: return 16'hFFFF;
         default: return 16'($urandom());
      endcase
   endfunction

   // Old normal placed near half a turn away, close by, or anywhere.
   function automatic logic [15:0] paired_normal(logic [15:0] anchor);
      logic [7:0] lat_off;
      logic [7:0] lon_off;
      case ($urandom_range(3))
         0: begin
            lat_off = 8'($urandom_range(131, 125));
            lon_off = 8'($urandom_range(131, 125));
         end
         1: begin
            lat_off = 8'($urandom_range(6) - 3);
            lon_off = 8'($urandom_range(6) - 3);
         end
         default: return 16'($urandom());
      endcase
      return {anchor[15:8] + lat_off, anchor[7:0] + lon_off};
   endfunction

   function automatic req_beat_type random_vertex();
      req_beat_type v;
      v.old_x = random_position();
      v.old_y = random_position();
      v.old_z = random_position();
      v.new_x = random_position();
      v.new_y = random_position();
      v.new_z = random_position();
      v.new_packed_normal = 16'($urandom());
      v.old_packed_normal = paired_normal(v.new_packed_normal);
      return v;
   endfunction

   // Result side: checks each accepted beat and stalls at random, once for a long stretch.
   initial begin : result_sink
      int hold_left;
      hold_left = 0;
      forever begin
         @(posedge clock);
         if (!reset) begin
            if (rsp_valid && !rsp_stall) begin
               blend_board.check_result(rsp_data);
            end
            if (pressure_armed && !pressure_done) begin
               hold_left     = HOLD_OFF_CYCLES;
               pressure_done = 1'b1;
            end
            if (hold_left > 0) begin
               hold_left = hold_left - 1;
               rsp_stall <= 1'b1;
            end else if (stall_enable) begin
               rsp_stall <= ($urandom_range(99) < IDLE_PERCENT);
            end else begin
               rsp_stall <= 1'b0;
            end
         end
      end
   end

   // Cycle budget for the whole run.
   initial begin : watchdog
      int cycles;
      cycles = 0;
      while (cycles < CYCLE_LIMIT) begin
         @(posedge clock);
         cycles = cycles + 1;
      end
      $display("%0t: run exceeded %0d cycles", $time, CYCLE_LIMIT);
      $display("Test completed with failures");
      $finish;
   end

   initial begin : stimulus
      req_beat_type          directed_beats[$];
      int                    phase_weight[RAND_PHASES];
      int                    w;
      logic [CSR_DATA_W-1:0] word;
      logic [CSR_DATA_W-1:0] rdata;
      blend_board = new();
      phase_weight = '{0, 256, 128, 1, 255, 300, 511, -1, -1, -1};
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Weight comes out of reset as zero; a write to an unused index leaves it alone.
      verify_weight();
      csr_cycle(1'b1, UNUSED_REG_INDEX, 32'd77, rdata);
      verify_weight();

      // Copy of the new frame, with extreme positions and the normal's axis points.
      directed_beats.push_back(make_vertex(32767, 32767, 32767, 'hFFFF,
                                           -32768, -32768, -32768, 'h0000));
      directed_beats.push_back(make_vertex(-32768, -32768, -32768, 'h0000,
                                           32767, 32767, 32767, 'hFFFF));
      directed_beats.push_back(make_vertex(0, 0, 0, 'h1234, 0, 0, 0, 'h4000));
      directed_beats.push_back(make_vertex(-1, 1, -1, 'h8080, 12345, -12345, 1, 'h0040));
      directed_beats.push_back(make_vertex(100, -100, 7, 'h3377, -2, 2, -7, 'hC0C0));
      foreach (directed_beats[i]) send_beat(directed_beats[i]);
      close_phase();

      // Full old-frame weight: positions reach both ends of the blended range.
      directed_beats.delete();
      program_weight(32'd256);
      directed_beats.push_back(make_vertex(-32768, 32767, -1, 'hABCD, 32767, -32768, 0, 'h55AA));
      directed_beats.push_back(make_vertex(32767, -32768, 1, 'h0000, -1, -1, -1, 'hFFFF));
      foreach (directed_beats[i]) send_beat(directed_beats[i]);
      close_phase();

      // Partial weight with junk in the upper data bits: exact half turns and wrapped deltas.
      directed_beats.delete();
      program_weight(32'hA5A5_A400 | 32'd96);
      directed_beats.push_back(make_vertex(1, 2, 3, 'h8080, 4, 5, 6, 'h0000));
      directed_beats.push_back(make_vertex(-1, -2, -3, 'h0000, -4, -5, -6, 'h8080));
      directed_beats.push_back(make_vertex(32767, 0, -32768, 'h8181, 0, 32767, 0, 'h0000));
      directed_beats.push_back(make_vertex(0, 0, 0, 'h0000, 32767, -32768, 32767, 'h8181));
      directed_beats.push_back(make_vertex(-32768, -32768, 0, 'hFFFF, 32767, 32767, 0, 'h0000));
      directed_beats.push_back(make_vertex(5, 5, 5, 'h0000, -5, -5, -5, 'hFFFF));
      directed_beats.push_back(make_vertex(300, -300, 9, 'h7F01, -300, 300, -9, 'h00FE));
      foreach (directed_beats[i]) send_beat(directed_beats[i]);
      close_phase();

      // Random phases over a spread of weights, out-of-range ones included.
      for (int p = 0; p < RAND_PHASES; p++) begin
         idle_enable    = (p != QUIET_PHASE);
         stall_enable   = (p != QUIET_PHASE);
         pressure_armed = (p == PRESSURE_PHASE);
         w    = (phase_weight[p] < 0) ? int'($urandom_range(256)) : phase_weight[p];
         word = CSR_DATA_W'(w);
         if (p % 2 == 1) begin
            word = ($urandom() & 32'hFFFF_FE00) | word;
         end
         program_weight(word);
         repeat (BEATS_PER_PHASE) send_beat(random_vertex());
         close_phase();
      end

      $display("Streamed %0d vertex beats across %0d weight settings, including copy mode,",
               blend_board.accepted, RAND_PHASES + 3);
      $display("full and out-of-range weights, wrapped angles and a long output stall.");
      if (blend_board.pending() != 0) begin
         $display("%0t: %0d expected beats never arrived, expected 0, actual %0d", $time,
                  blend_board.pending(), blend_board.pending());
      end
      if (blend_board.mismatches == 0 && blend_board.pending() == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule
